FILE: hdl/srs_pkg.sv
package srs_pkg;

    // result status codes
    localparam logic [1:0] STATUS_CONVERGED = 2'd0;
    localparam logic [1:0] STATUS_LIMIT     = 2'd1;
    localparam logic [1:0] STATUS_ZERO_DEN  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_COEF_CUBIC    = 3'd0;
    localparam logic [2:0] REG_COEF_SQUARE   = 3'd1;
    localparam logic [2:0] REG_COEF_LINEAR   = 3'd2;
    localparam logic [2:0] REG_COEF_CONSTANT = 3'd3;
    localparam logic [2:0] REG_TOLERANCE     = 3'd4;
    localparam logic [2:0] REG_ITER_LIMIT    = 3'd5;

    localparam int TOL_WIDTH   = 33;
    localparam int COUNT_WIDTH = 6;

    // arithmetic unit operation codes
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3
    } srs_op_t;

    // request / response between sequencer and arithmetic unit
    typedef struct packed {
        logic    start;
        srs_op_t op;
    } srs_alu_ctl_t;

    typedef struct packed {
        logic done;
        logic busy;
    } srs_alu_sts_t;

endpackage

FILE: hdl/srs_alu.sv
// Shared saturating fixed-point unit: add/sub registered in the cycle after start,
// multiply one 16-bit slice of b at a time, divide one quotient bit per cycle.
module srs_alu
    import srs_pkg::*;
#(
    parameter int DATA_WIDTH = 48,
    parameter int FRAC_BITS  = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  srs_alu_ctl_t                 ctl,
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    output srs_alu_sts_t                 sts,
    output logic signed [DATA_WIDTH-1:0] res
);

    localparam int W      = DATA_WIDTH;
    localparam int SLICE  = 16;
    localparam int NSLICE = (W + SLICE - 1) / SLICE;
    localparam int PW     = 2 * W;
    localparam int NB     = W + FRAC_BITS;
    localparam int CW     = $clog2(NB + 1);
    localparam int SW     = $clog2(NSLICE + 1);

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_MUL  = 3'b010,
        A_DIV  = 3'b100
    } alu_state_t;

    alu_state_t       state_reg, state_next;
    logic [W-1:0]     ma_reg, mb_reg;
    logic             neg_reg;
    logic [PW-1:0]    prod_reg;
    logic [SW-1:0]    slice_reg;
    logic [NB-1:0]    num_reg;
    logic [W:0]       rem_reg;
    logic [NB-1:0]    quo_reg;
    logic [CW-1:0]    cnt_reg;
    logic [W-1:0]     res_reg;
    logic             done_reg;
    logic             prod_valid_q, quo_valid_q;

    logic [W-1:0]     mag_a, mag_b;
    logic [W:0]       sum_w;
    logic [W-1:0]     sat_sum;
    logic [SLICE-1:0] bslice;
    logic [W+SLICE-1:0] part;
    logic [W:0]       rem_sh, rem_sub;
    logic             take;
    logic [PW-1:0]    prod_sh;
    logic             mul_ovf, div_ovf;
    logic [W-1:0]     mul_mag, div_mag;

    function automatic logic [W-1:0] sat_mag(input logic neg, input logic [W-1:0] m,
                                             input logic ovf);
        logic [W-1:0] r;
        r = '0;
        if (neg) begin
            if (ovf || m[W-1]) r = {1'b1, {(W-1){1'b0}}};
            else               r = (~m) + 1'b1;
        end else begin
            if (ovf || m[W-1]) r = {1'b0, {(W-1){1'b1}}};
            else               r = m;
        end
        return r;
    endfunction

    assign mag_a = a[W-1] ? (~a) + 1'b1 : a;
    assign mag_b = b[W-1] ? (~b) + 1'b1 : b;

    // saturating add / subtract
    always_comb
    begin
        if (ctl.op == OP_SUB) sum_w = {a[W-1], a} - {b[W-1], b};
        else                  sum_w = {a[W-1], a} + {b[W-1], b};
        if (sum_w[W] != sum_w[W-1])
            sat_sum = sum_w[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            sat_sum = sum_w[W-1:0];
    end

    // multiply slice and divide step
    assign bslice  = mb_reg[slice_reg*SLICE +: SLICE];
    assign part    = ma_reg * bslice;
    assign rem_sh  = {rem_reg[W-1:0], num_reg[NB-1]};
    assign take    = (rem_sh >= {1'b0, mb_reg});
    assign rem_sub = rem_sh - {1'b0, mb_reg};

    assign prod_sh = prod_reg >> FRAC_BITS;
    assign mul_ovf = |(prod_reg >> (FRAC_BITS + W));
    assign mul_mag = prod_sh[W-1:0];
    assign div_ovf = |(quo_reg >> W);
    assign div_mag = quo_reg[W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (ctl.start && ctl.op == OP_MUL) state_next = A_MUL;
                if (ctl.start && ctl.op == OP_DIV) state_next = A_DIV;
            end
            A_MUL:   if (slice_reg == SW'(NSLICE - 1)) state_next = A_IDLE;
            A_DIV:   if (cnt_reg == CW'(NB - 1)) state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == A_IDLE) && ctl.start &&
                          (ctl.op == OP_ADD || ctl.op == OP_SUB)) ||
                         ((state_reg == A_MUL) && (slice_reg == SW'(NSLICE - 1))) ||
                         ((state_reg == A_DIV) && (cnt_reg == CW'(NB - 1)));
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            A_IDLE:
            begin
                ma_reg    <= mag_a;
                mb_reg    <= mag_b;
                neg_reg   <= a[W-1] ^ b[W-1];
                prod_reg  <= '0;
                slice_reg <= '0;
                num_reg   <= {mag_a, {FRAC_BITS{1'b0}}};
                rem_reg   <= '0;
                quo_reg   <= '0;
                cnt_reg   <= '0;
                if (ctl.start && (ctl.op == OP_ADD || ctl.op == OP_SUB))
                    res_reg <= sat_sum;
            end
            A_MUL:
            begin
                prod_reg  <= prod_reg + (PW'(part) << (slice_reg * SLICE));
                slice_reg <= slice_reg + 1'b1;
            end
            A_DIV:
            begin
                rem_reg <= take ? rem_sub : rem_sh;
                quo_reg <= {quo_reg[NB-2:0], take};
                num_reg <= {num_reg[NB-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // final sign and saturation
    always_comb
    begin
        res = res_reg;
        if (done_reg && prod_valid_q) res = sat_mag(neg_reg, mul_mag, mul_ovf);
        if (done_reg && quo_valid_q)  res = sat_mag(neg_reg, div_mag, div_ovf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_q <= 1'b0;
            quo_valid_q  <= 1'b0;
        end
        else
        begin
            prod_valid_q <= (state_reg == A_MUL);
            quo_valid_q  <= (state_reg == A_DIV);
        end
    end

    assign sts.done = done_reg;
    assign sts.busy = (state_reg != A_IDLE);

endmodule

FILE: hdl/secant_root_solver.sv
// Channel | valid        | stall        | payload
// request | x_valid      | x_stall      | x_first, x_second
// result  | result_valid | result_stall | root, status, iterations_used
//
// The bit-serial divide in the shared unit dominates the time of each secant
// step. Reset is asynchronous, active low, and restores the coefficient
// registers. A stalled result holds; the next request is taken only after the
// result has been delivered.
module secant_root_solver
    import srs_pkg::*;
#(
    parameter int DATA_WIDTH = 48,
    parameter int FRAC_BITS  = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [DATA_WIDTH-1:0]        cfg_data,
    input  logic                         x_valid,
    output logic                         x_stall,
    input  logic signed [DATA_WIDTH-1:0] x_first,
    input  logic signed [DATA_WIDTH-1:0] x_second,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [DATA_WIDTH-1:0] root,
    output logic [1:0]                   status,
    output logic [COUNT_WIDTH-1:0]       iterations_used
);

    localparam int W = DATA_WIDTH;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_PSTART = 13'b0000000000010,
        S_PMUL   = 13'b0000000000100,
        S_PADD   = 13'b0000000001000,
        S_PDONE  = 13'b0000000010000,
        S_CHECK  = 13'b0000000100000,
        S_DEN    = 13'b0000001000000,
        S_DX     = 13'b0000010000000,
        S_DIV    = 13'b0000100000000,
        S_MUL    = 13'b0001000000000,
        S_TEST   = 13'b0010000000000,
        S_UPD    = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } seq_state_t;

    seq_state_t state_reg;
    logic [W-1:0] c3_reg, c2_reg, c1_reg, c0_reg;
    logic [TOL_WIDTH-1:0]   tol_reg;
    logic [COUNT_WIDTH-1:0] lim_reg, iter_reg;
    logic signed [W-1:0] xa_reg, xb_reg, fa_reg, fb_reg, acc_reg, px_reg, t_reg;
    logic [1:0] hstep_reg;
    logic       pfor_b_reg;
    logic       first_reg;
    logic       waiting_reg;
    logic signed [W-1:0] root_reg;
    logic [1:0] status_reg;
    logic [COUNT_WIDTH-1:0] used_reg;
    logic       out_valid_reg;

    srs_alu_ctl_t ctl;
    srs_alu_sts_t sts;
    logic signed [W-1:0] op_a, op_b, alu_res;
    logic [W-1:0] d_mag;

    srs_alu #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .a     (op_a),
        .b     (op_b),
        .sts   (sts),
        .res   (alu_res)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c3_reg  <= W'(64'sd4294967296 >>> (32 - FRAC_BITS));
            c2_reg  <= W'(-64'sd12884901888 >>> (32 - FRAC_BITS));
            c1_reg  <= W'(64'sd8589934592 >>> (32 - FRAC_BITS));
            c0_reg  <= '0;
            tol_reg <= TOL_WIDTH'(1);
            lim_reg <= COUNT_WIDTH'(50);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COEF_CUBIC:    c3_reg  <= cfg_data;
                REG_COEF_SQUARE:   c2_reg  <= cfg_data;
                REG_COEF_LINEAR:   c1_reg  <= cfg_data;
                REG_COEF_CONSTANT: c0_reg  <= cfg_data;
                REG_TOLERANCE:     tol_reg <= TOL_WIDTH'(cfg_data);
                REG_ITER_LIMIT:    lim_reg <= cfg_data[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // operand selection for the shared unit
    always_comb
    begin
        ctl.start = 1'b0;
        ctl.op    = OP_ADD;
        op_a      = acc_reg;
        op_b      = px_reg;
        case (state_reg)
            S_PMUL:
            begin
                ctl.start = !waiting_reg;
                ctl.op    = OP_MUL;
            end
            S_PADD:
            begin
                ctl.start = !waiting_reg;
                ctl.op    = OP_ADD;
                op_b      = (hstep_reg == 2'd0) ? c2_reg :
                            (hstep_reg == 2'd1) ? c1_reg : c0_reg;
            end
            S_DEN:
            begin
                ctl.start = !waiting_reg;
                ctl.op    = OP_SUB;
                op_a      = fb_reg;
                op_b      = fa_reg;
            end
            S_DX:
            begin
                ctl.start = !waiting_reg;
                ctl.op    = OP_SUB;
                op_a      = xb_reg;
                op_b      = xa_reg;
            end
            S_DIV:
            begin
                ctl.start = !waiting_reg;
                ctl.op    = OP_DIV;
                op_a      = t_reg;
                op_b      = acc_reg;
            end
            S_MUL:
            begin
                ctl.start = !waiting_reg;
                ctl.op    = OP_MUL;
                op_a      = t_reg;
                op_b      = fb_reg;
            end
            S_UPD:
            begin
                ctl.start = !waiting_reg;
                ctl.op    = OP_SUB;
                op_a      = xb_reg;
                op_b      = t_reg;
            end
            default: ;
        endcase
    end

    assign d_mag = t_reg[W-1] ? (~t_reg) + 1'b1 : t_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            waiting_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sts.done)       waiting_reg <= 1'b0;
            else if (ctl.start) waiting_reg <= 1'b1;
            case (state_reg)
                S_IDLE:
                    if (x_valid)
                    begin
                        xa_reg     <= x_first;
                        xb_reg     <= x_second;
                        iter_reg   <= '0;
                        px_reg     <= x_first;
                        pfor_b_reg <= 1'b0;
                        first_reg  <= 1'b1;
                        state_reg  <= S_PSTART;
                    end
                S_PSTART:
                begin
                    acc_reg   <= c3_reg;
                    hstep_reg <= 2'd0;
                    state_reg <= S_PMUL;
                end
                S_PMUL:
                    if (sts.done)
                    begin
                        acc_reg   <= alu_res;
                        state_reg <= S_PADD;
                    end
                S_PADD:
                    if (sts.done)
                    begin
                        acc_reg   <= alu_res;
                        hstep_reg <= hstep_reg + 1'b1;
                        state_reg <= (hstep_reg == 2'd2) ? S_PDONE : S_PMUL;
                    end
                S_PDONE:
                begin
                    if (pfor_b_reg) fb_reg <= acc_reg;
                    else            fa_reg <= acc_reg;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (!pfor_b_reg && first_reg)
                    begin
                        first_reg <= 1'b0;
                        if (iter_reg == lim_reg)
                        begin
                            root_reg   <= xb_reg;
                            status_reg <= STATUS_LIMIT;
                            used_reg   <= lim_reg;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            px_reg     <= xb_reg;
                            pfor_b_reg <= 1'b1;
                            state_reg  <= S_PSTART;
                        end
                    end
                    else
                        state_reg <= S_DEN;
                end
                S_DEN:
                    if (sts.done)
                    begin
                        acc_reg <= alu_res;
                        if (alu_res == '0)
                        begin
                            root_reg   <= xb_reg;
                            status_reg <= STATUS_ZERO_DEN;
                            used_reg   <= iter_reg;
                            state_reg  <= S_OUT;
                        end
                        else
                            state_reg <= S_DX;
                    end
                S_DX:
                    if (sts.done)
                    begin
                        t_reg     <= alu_res;
                        state_reg <= S_DIV;
                    end
                S_DIV:
                    if (sts.done)
                    begin
                        t_reg     <= alu_res;
                        state_reg <= S_MUL;
                    end
                S_MUL:
                    if (sts.done)
                    begin
                        t_reg     <= alu_res;
                        state_reg <= S_TEST;
                    end
                S_TEST:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if ({1'b0, d_mag} < (W+1)'(tol_reg))
                    begin
                        root_reg   <= xb_reg;
                        status_reg <= STATUS_CONVERGED;
                        used_reg   <= iter_reg + 1'b1;
                        state_reg  <= S_OUT;
                    end
                    else
                        state_reg <= S_UPD;
                end
                S_UPD:
                    if (sts.done)
                    begin
                        xa_reg <= xb_reg;
                        fa_reg <= fb_reg;
                        xb_reg <= alu_res;
                        px_reg <= alu_res;
                        if (iter_reg == lim_reg)
                        begin
                            root_reg   <= alu_res;
                            status_reg <= STATUS_LIMIT;
                            used_reg   <= lim_reg;
                            state_reg  <= S_OUT;
                        end
                        else
                            state_reg <= S_PSTART;
                    end
                S_OUT:
                begin
                    if (!out_valid_reg) out_valid_reg <= 1'b1;
                    else if (!result_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign x_stall         = (state_reg != S_IDLE);
    assign result_valid    = out_valid_reg;
    assign root            = root_reg;
    assign status          = status_reg;
    assign iterations_used = used_reg;

endmodule

FILE: hdl/srs_checker.sv
module srs_checker
    import srs_pkg::*;
#(
    parameter int DATA_WIDTH = 48
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   x_valid,
    input logic                   x_stall,
    input logic                   result_valid,
    input logic                   result_stall,
    input logic [DATA_WIDTH-1:0]  root,
    input logic [1:0]             status,
    input logic [COUNT_WIDTH-1:0] iterations_used
);

    // a result never shows while a new request can be taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> x_stall) else $error("request open while result pending");

    // a request is followed by busy
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (x_valid && !x_stall) |=> x_stall) else $error("not busy after request");

    // status code is legal
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == STATUS_CONVERGED || status == STATUS_LIMIT ||
                          status == STATUS_ZERO_DEN)) else $error("bad status");

    // a converged result has run at least one step
    a_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == STATUS_CONVERGED) |-> (iterations_used != '0))
        else $error("converged without a step");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(root)))
        else $error("stalled result changed");

endmodule

bind secant_root_solver srs_checker #(.DATA_WIDTH(DATA_WIDTH)) u_srs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .x_valid         (x_valid),
    .x_stall         (x_stall),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .root            (root),
    .status          (status),
    .iterations_used (iterations_used)
);

FILE: sim/tb.sv
module tb
    import srs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     W          = 48;
    localparam int     F          = 32;
    localparam longint VMAX       = (64'sd1 <<< (W - 1)) - 1;
    localparam longint VMIN       = -(64'sd1 <<< (W - 1));
    localparam longint ONE        = 64'sd1 <<< F;
    localparam int     IDLE_LIMIT = 100000;

    typedef struct packed {
        logic [W-1:0]           root;
        logic [1:0]             status;
        logic [COUNT_WIDTH-1:0] iters;
    } solution_t;

    typedef struct packed {
        logic [W-1:0] xf;
        logic [W-1:0] xs;
        logic         typed;
        solution_t    sol;
    } dir_row_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [2:0]           cfg_index    = '0;
    logic [W-1:0]         cfg_data     = '0;
    logic                 x_valid      = 1'b0;
    logic                 x_stall;
    logic signed [W-1:0]  x_first      = '0;
    logic signed [W-1:0]  x_second     = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic signed [W-1:0]  root;
    logic [1:0]           status;
    logic [COUNT_WIDTH-1:0] iterations_used;

    // mirror of the configuration registers
    longint coef [4];
    longint tol_q;
    int     iter_cap;

    solution_t pending_roots [$];
    int        errors      = 0;
    int        checked     = 0;
    int        status_seen [4];
    int        idle_cycles = 0;
    bit        quiet       = 1'b0;
    int        stall_left  = 0;

    secant_root_solver DUT (.*);

    always #1 clk = ~clk;

    // directed requests under the reset polynomial x^3 - 3x^2 + 2x
    dir_row_t dir_rows [] = '{
        '{48'd0, 48'd0, 1'b1, '{48'd0, STATUS_ZERO_DEN, 6'd0}},
        '{W'(VMAX), W'(VMAX), 1'b1, '{W'(VMAX), STATUS_ZERO_DEN, 6'd0}},
        '{W'(VMIN), W'(VMIN), 1'b1, '{W'(VMIN), STATUS_ZERO_DEN, 6'd0}},
        '{W'(3 * ONE), W'(ONE), 1'b1, '{W'(ONE), STATUS_CONVERGED, 6'd1}},
        '{W'(3 * ONE), W'(2 * ONE), 1'b1, '{W'(2 * ONE), STATUS_CONVERGED, 6'd1}},
        '{48'd0, W'(ONE), 1'b1, '{W'(ONE), STATUS_ZERO_DEN, 6'd0}},
        '{W'(ONE), W'(2 * ONE), 1'b1, '{W'(2 * ONE), STATUS_ZERO_DEN, 6'd0}},
        '{W'(ONE / 2), W'(3 * ONE / 2), 1'b0, '0},
        '{W'(5 * ONE / 2), W'(3 * ONE), 1'b0, '0},
        '{W'(-ONE), W'(-ONE / 2), 1'b0, '0},
        '{W'(VMIN), W'(VMAX), 1'b0, '0},
        '{W'(VMAX), W'(VMIN), 1'b0, '0},
        '{W'(VMIN), 48'd0, 1'b0, '0},
        '{48'd0, W'(VMAX), 1'b0, '0},
        '{W'(ONE), 48'd1, 1'b0, '0},
        '{48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b0, '0}
    };

    // ---------------- fixed-point predictor ----------------
    function automatic longint clamp(input longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    function automatic logic [127:0] magnitude(input longint a);
        return (a < 0) ? 128'(-a) : 128'(a);
    endfunction

    function automatic longint signed_from(input bit neg, input logic [127:0] m);
        if (neg) return (m >= 128'(64'sd1 <<< (W - 1))) ? VMIN : -longint'(m[63:0]);
        return (m > 128'(VMAX)) ? VMAX : longint'(m[63:0]);
    endfunction

    function automatic longint q_mul(input longint a, input longint b);
        logic [127:0] p;
        p = magnitude(a) * magnitude(b);
        return signed_from((a < 0) != (b < 0), p >> F);
    endfunction

    function automatic longint q_div(input longint a, input longint b);
        logic [127:0] q;
        q = (magnitude(a) << F) / magnitude(b);
        return signed_from((a < 0) != (b < 0), q);
    endfunction

    function automatic longint cubic_at(input longint x);
        longint acc;
        acc = coef[0];
        acc = clamp(q_mul(acc, x) + coef[1]);
        acc = clamp(q_mul(acc, x) + coef[2]);
        acc = clamp(q_mul(acc, x) + coef[3]);
        return acc;
    endfunction

    function automatic solution_t solve_secant(input logic signed [W-1:0] xf,
                                               input logic signed [W-1:0] xs);
        longint    xa, xb, fa, fb, den, d;
        solution_t s;
        xa = xf;
        xb = xs;
        fa = cubic_at(xa);
        s.status = STATUS_LIMIT;
        s.iters  = COUNT_WIDTH'(iter_cap);
        for (int i = 0; i < iter_cap; i++)
        begin
            fb  = cubic_at(xb);
            den = clamp(fb - fa);
            if (den == 0)
            begin
                s.status = STATUS_ZERO_DEN;
                s.iters  = COUNT_WIDTH'(i);
                break;
            end
            d = q_mul(q_div(clamp(xb - xa), den), fb);
            if (magnitude(d) < 128'(tol_q))
            begin
                s.status = STATUS_CONVERGED;
                s.iters  = COUNT_WIDTH'(i + 1);
                break;
            end
            xa = xb;
            fa = fb;
            xb = clamp(xb - d);
        end
        s.root = W'(xb);
        return s;
    endfunction

    // ---------------- value sources ----------------
    function automatic logic [W-1:0] rand_word();
        return W'({$urandom, $urandom});
    endfunction

    // signed value within +/- 2^(bits-1)
    function automatic longint rand_near(input int bits);
        longint v;
        v = {$urandom, $urandom};
        v = v & ((64'sd1 <<< bits) - 1);
        return v - (64'sd1 <<< (bits - 1));
    endfunction

    // ---------------- drivers ----------------
    task automatic write_reg(input logic [2:0] idx, input longint value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= W'(value);
        case (idx)
            REG_TOLERANCE:  tol_q    = value & 64'h1_FFFF_FFFF;
            REG_ITER_LIMIT: iter_cap = int'(value & 64'h3F);
            default:        coef[idx] = longint'(signed'(W'(value)));
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setup(input longint c3, input longint c2, input longint c1,
                              input longint c0, input longint tol, input int lim);
        write_reg(REG_COEF_CUBIC, c3);
        write_reg(REG_COEF_SQUARE, c2);
        write_reg(REG_COEF_LINEAR, c1);
        write_reg(REG_COEF_CONSTANT, c0);
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_ITER_LIMIT, lim);
    endtask

    // offer one request; the expectation is queued once it is taken
    task automatic send_request(input logic [W-1:0] xf, input logic [W-1:0] xs,
                                input bit typed, input solution_t sol);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 9);
            x_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        x_valid  <= 1'b1;
        x_first  <= xf;
        x_second <= xs;
        do @(posedge clk); while (x_stall);
        pending_roots.push_back(typed ? sol : solve_secant(xf, xs));
    endtask

    task automatic drain();
        @(negedge clk);
        x_valid <= 1'b0;
        while (pending_roots.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // ---------------- result side stall ----------------
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 5) == 0)
                stall_left <= $urandom_range(1, 9);
        end
    end

    // ---------------- result check and watchdog ----------------
    always @(posedge clk)
    begin
        solution_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            idle_cycles <= 0;
            if (pending_roots.size() == 0)
            begin
                $display("%0t: unexpected result root=%h status=%0d iters=%0d",
                         $time, root, status, iterations_used);
                errors++;
            end
            else
            begin
                e = pending_roots.pop_front();
                checked++;
                status_seen[status]++;
                if (root !== e.root)
                begin
                    $display("%0t: root expected %h actual %h", $time, e.root, root);
                    errors++;
                end
                if (status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                    errors++;
                end
                if (iterations_used !== e.iters)
                begin
                    $display("%0t: iterations expected %0d actual %0d",
                             $time, e.iters, iterations_used);
                    errors++;
                end
            end
        end
        else if (rst_n && x_valid && !x_stall)
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout with %0d results outstanding",
                         $time, pending_roots.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // ---------------- test sequence ----------------
    initial
    begin
        int     kind, n_items, lim;
        longint tol, xa, xb;
        coef[0]  = ONE;
        coef[1]  = -3 * ONE;
        coef[2]  = 2 * ONE;
        coef[3]  = 0;
        tol_q    = 1;
        iter_cap = 50;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // directed part under reset values
        foreach (dir_rows[i])
            send_request(dir_rows[i].xf, dir_rows[i].xs, dir_rows[i].typed, dir_rows[i].sol);
        drain();

        // randomized phases, each with its own polynomial and stop rule
        for (int ph = 0; ph < 9; ph++)
        begin
            n_items = 22;
            case (ph)
                0:
                begin
                    // zero tolerance, longest limit: only limit or flat slope stop it
                    load_setup(ONE, -3 * ONE, 2 * ONE, 0, 0, 63);
                    n_items = 5;
                end
                1: load_setup(rand_near(36), rand_near(36), rand_near(36), rand_near(36),
                              ONE, 1);
                2: load_setup(VMAX, VMIN, VMAX, VMIN, $urandom_range(0, 65535), 7);
                3: load_setup(VMIN, VMAX, VMIN, VMAX, {$urandom_range(0, 1), $urandom},
                              $urandom_range(1, 12));
                default:
                begin
                    tol = ($urandom_range(0, 3) == 0) ? {$urandom_range(0, 1), $urandom}
                                                      : $urandom_range(0, 1 << 20);
                    lim = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
                    load_setup(rand_near(36), rand_near(36), rand_near(36), rand_near(36),
                               tol, lim);
                end
            endcase
            quiet = (ph == 8);
            for (int k = 0; k < n_items; k++)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 7)
                begin
                    xa = rand_near(35);
                    xb = rand_near(35);
                end
                else if (kind < 9)
                begin
                    xa = signed'(rand_word());
                    xb = signed'(rand_word());
                end
                else
                begin
                    xa = signed'(rand_word());
                    xb = xa;
                end
                send_request(W'(xa), W'(xb), 1'b0, '0);
            end
            drain();
        end

        $display("Checked %0d results: %0d converged, %0d at limit, %0d flat slope",
                 checked, status_seen[STATUS_CONVERGED], status_seen[STATUS_LIMIT],
                 status_seen[STATUS_ZERO_DEN]);
        $display("Covered reset polynomial, extreme coefficients and tolerance, limits 1..63");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
